>>> design/pli_pkg.sv
// Shared types and constants of the piecewise linear interpolator.
package pli_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int XW         = 32;
    localparam int FRAC_W     = 16;
    localparam int DIV_STEPS  = XW + FRAC_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int MUL_A_W    = 18;
    localparam int LO_W       = MUL_A_W - 1;
    localparam int PROD_W     = MUL_A_W + XW;
    localparam int ACC_W      = 2 * XW + 2;

    localparam logic [XW-1:0] Q_MAX = {1'b0, {(XW-1){1'b1}}};
    localparam logic [XW-1:0] Q_MIN = {1'b1, {(XW-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_EVAL  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FEW   = 3'd1,
        ST_FULL  = 3'd2,
        ST_ORDER = 3'd3,
        ST_SAT   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ADDR_LAST,
        ADDR_MID,
        ADDR_SRCH
    } addr_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_READ,
        S_LD_CHECK,
        S_DIV,
        S_LD_WRITE,
        S_SRCH_START,
        S_SRCH,
        S_EV_DIFF,
        S_EV_MUL_LO,
        S_EV_MUL_HI,
        S_EV_ACC,
        S_EV_FIN,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic      capture;
        logic      cnt_clear;
        logic      knot_wr;
        addr_sel_t addr_sel;
        logic      search_init;
        logic      search_step;
        logic      div_init;
        logic      div_step;
        logic      ev_diff;
        logic      ev_mul_lo;
        logic      ev_mul_hi;
        logic      ev_acc;
        logic      ev_fin;
        logic      res_load;
        logic      res_eval;
        status_t   res_status;
    } dp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic count_few;
        logic order_err;
        logic search_done;
        logic div_done;
        logic slope_sat;
        logic ev_sat;
    } dp_stat_t;

endpackage

>>> design/pli_dp.sv
// Datapath: knot memories, binary search, slope divider, multiply and saturate.
module pli_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [pli_pkg::XW-1:0]  in_x,
    input  logic [pli_pkg::XW-1:0]  in_y,
    input  pli_pkg::dp_cmd_t        cmd,
    output pli_pkg::dp_stat_t       stat,
    output logic [pli_pkg::XW-1:0]  value,
    output logic [2:0]              status
);

    localparam int XW    = pli_pkg::XW;
    localparam int IDX_W = pli_pkg::IDX_W;
    localparam int CNT_W = pli_pkg::CNT_W;
    localparam int ACC_W = pli_pkg::ACC_W;
    localparam int PW    = pli_pkg::PROD_W;
    localparam int LO_W  = pli_pkg::LO_W;
    localparam int MAW   = pli_pkg::MUL_A_W;
    localparam int DSW   = pli_pkg::DIV_STEPS;

    logic signed [XW-1:0]    x_reg, y_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [IDX_W-1:0]        lo_reg, hi_reg, mid_reg;

    logic signed [XW-1:0]    knot_x_mem [pli_pkg::MAX_POINTS];
    logic signed [XW-1:0]    knot_y_mem [pli_pkg::MAX_POINTS];
    logic signed [XW-1:0]    slope_mem  [pli_pkg::MAX_POINTS];
    logic signed [XW-1:0]    rd_x_reg, rd_y_reg, rd_s_reg;

    logic [DSW-1:0]          q_reg;
    logic [XW-1:0]           rem_reg, d_reg;
    logic                    neg_reg;
    logic [pli_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic signed [XW:0]      dx_reg;
    logic signed [XW-1:0]    ky_reg, sl_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [XW-1:0]           ev_val_reg;
    logic                    ev_sat_reg;
    logic [XW-1:0]           value_reg;
    logic [2:0]              status_reg;

    logic [CNT_W-1:0]        cnt_last;
    logic [IDX_W-1:0]        last_idx, wr_idx, rd_addr;
    logic [IDX_W:0]          sum_cur, sum_nxt;
    logic [IDX_W-1:0]        mid_cur, mid_nxt, lo_nxt, hi_nxt, idx_sel;
    logic                    go_right, search_done;

    logic [XW:0]             dy, dy_mag, dxl;
    logic [XW:0]             rem_sh, rem_sub;
    logic                    rem_ge;
    logic                    sat_pos, sat_neg;
    logic [XW-1:0]           slope_val;

    logic signed [MAW-1:0]   mul_a;
    logic signed [PW-1:0]    mul_p;
    logic signed [ACC_W-1:0] prod_ext, acc_shr, ev_sum;
    logic                    ev_over;

    assign cnt_last = count_reg - CNT_W'(1);
    assign last_idx = cnt_last[IDX_W-1:0];
    assign wr_idx   = count_reg[IDX_W-1:0];

    // Search: each step compares the knot read at mid_reg and issues the next read.
    assign sum_cur  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_cur  = sum_cur[IDX_W:1];
    assign go_right = rd_x_reg < x_reg;
    assign lo_nxt   = go_right ? mid_reg + IDX_W'(1) : lo_reg;
    assign hi_nxt   = go_right ? hi_reg : mid_reg;
    assign sum_nxt  = {1'b0, lo_nxt} + {1'b0, hi_nxt};
    assign mid_nxt  = sum_nxt[IDX_W:1];
    assign search_done = (lo_nxt == hi_nxt);
    assign idx_sel  = (lo_nxt == '0) ? '0 : lo_nxt - IDX_W'(1);

    always_comb
    begin
        unique case (cmd.addr_sel)
            pli_pkg::ADDR_LAST: rd_addr = last_idx;
            pli_pkg::ADDR_MID:  rd_addr = mid_cur;
            pli_pkg::ADDR_SRCH: rd_addr = search_done ? idx_sel : mid_nxt;
            default:            rd_addr = mid_cur;
        endcase
    end

    // Slope divider operands and one restoring step.
    assign dy      = {y_reg[XW-1], y_reg} - {rd_y_reg[XW-1], rd_y_reg};
    assign dy_mag  = dy[XW] ? ((XW+1)'(0) - dy) : dy;
    assign dxl     = {x_reg[XW-1], x_reg} - {rd_x_reg[XW-1], rd_x_reg};
    assign rem_sh  = {rem_reg, q_reg[DSW-1]};
    assign rem_ge  = rem_sh >= {1'b0, d_reg};
    assign rem_sub = rem_sh - {1'b0, d_reg};

    assign sat_pos = !neg_reg && (|q_reg[DSW-1:XW-1]);
    assign sat_neg = neg_reg && ((|q_reg[DSW-1:XW]) || (q_reg[XW-1] && (|q_reg[XW-2:0])));

    always_comb
    begin
        priority if (sat_pos)
            slope_val = pli_pkg::Q_MAX;
        else if (sat_neg)
            slope_val = pli_pkg::Q_MIN;
        else if (neg_reg)
            slope_val = XW'(0) - q_reg[XW-1:0];
        else
            slope_val = q_reg[XW-1:0];
    end

    // Split the 33-bit offset into an unsigned low part and a signed high part.
    assign mul_a    = cmd.ev_mul_lo ? $signed({1'b0, dx_reg[LO_W-1:0]})
                                    : $signed({{(MAW-(XW+1-LO_W)){dx_reg[XW]}},
                                               dx_reg[XW:LO_W]});
    assign mul_p    = mul_a * sl_reg;
    assign prod_ext = {{(ACC_W-PW){prod_reg[PW-1]}}, prod_reg};
    assign acc_shr  = acc_reg >>> pli_pkg::FRAC_W;
    assign ev_sum   = acc_shr + $signed({{(ACC_W-XW){ky_reg[XW-1]}}, ky_reg});
    assign ev_over  = !((&ev_sum[ACC_W-1:XW-1]) || !(|ev_sum[ACC_W-1:XW-1]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.cnt_clear)
        begin
            count_reg <= '0;
        end
        else if (cmd.knot_wr)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.knot_wr)
        begin
            knot_x_mem[wr_idx] <= x_reg;
        end
        rd_x_reg <= knot_x_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.knot_wr)
        begin
            knot_y_mem[wr_idx] <= y_reg;
        end
        rd_y_reg <= knot_y_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.knot_wr && (count_reg != '0))
        begin
            slope_mem[last_idx] <= slope_val;
        end
        rd_s_reg <= slope_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg <= in_x;
            y_reg <= in_y;
        end
        mid_reg <= (cmd.addr_sel == pli_pkg::ADDR_SRCH) ? mid_nxt : mid_cur;
        if (cmd.search_init)
        begin
            lo_reg <= '0;
            hi_reg <= last_idx;
        end
        else if (cmd.search_step)
        begin
            lo_reg <= lo_nxt;
            hi_reg <= hi_nxt;
        end
        if (cmd.div_init)
        begin
            q_reg       <= {dy_mag[XW-1:0], {pli_pkg::FRAC_W{1'b0}}};
            rem_reg     <= '0;
            d_reg       <= dxl[XW-1:0];
            neg_reg     <= dy[XW];
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            q_reg       <= {q_reg[DSW-2:0], rem_ge};
            rem_reg     <= rem_ge ? rem_sub[XW-1:0] : rem_sh[XW-1:0];
            div_cnt_reg <= div_cnt_reg + pli_pkg::DIV_CNT_W'(1);
        end
        if (cmd.ev_diff)
        begin
            dx_reg <= dxl;
            ky_reg <= rd_y_reg;
            sl_reg <= rd_s_reg;
        end
        if (cmd.ev_mul_lo || cmd.ev_mul_hi)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.ev_mul_hi)
        begin
            acc_reg <= prod_ext;
        end
        else if (cmd.ev_acc)
        begin
            acc_reg <= acc_reg + (prod_ext <<< LO_W);
        end
        if (cmd.ev_fin)
        begin
            ev_sat_reg <= ev_over;
            if (ev_over)
                ev_val_reg <= ev_sum[ACC_W-1] ? pli_pkg::Q_MIN : pli_pkg::Q_MAX;
            else
                ev_val_reg <= ev_sum[XW-1:0];
        end
        if (cmd.res_load)
        begin
            value_reg  <= cmd.res_eval ? ev_val_reg : '0;
            status_reg <= cmd.res_status;
        end
    end

    assign stat.count_zero  = (count_reg == '0);
    assign stat.count_full  = (count_reg == CNT_W'(pli_pkg::MAX_POINTS));
    assign stat.count_few   = (count_reg < CNT_W'(2));
    assign stat.order_err   = (x_reg <= rd_x_reg);
    assign stat.search_done = search_done;
    assign stat.div_done    = (div_cnt_reg == pli_pkg::DIV_CNT_W'(DSW - 1));
    assign stat.slope_sat   = sat_pos || sat_neg;
    assign stat.ev_sat      = ev_sat_reg;

    assign value  = value_reg;
    assign status = status_reg;

endmodule

>>> design/pli_ctrl.sv
// Controller: command sequencing state machine and output valid flag.
module pli_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_cmd,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output pli_pkg::dp_cmd_t  cmd,
    input  pli_pkg::dp_stat_t stat
);

    pli_pkg::state_t  state_reg, state_next;
    pli_pkg::status_t pend_status_reg, pend_status_next;
    logic             pend_eval_reg, pend_eval_next;
    logic             out_valid_reg;
    logic             out_free;
    pli_pkg::cmd_t    op;

    assign op       = pli_pkg::cmd_t'(in_cmd);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next       = state_reg;
        pend_status_next = pend_status_reg;
        pend_eval_next   = pend_eval_reg;
        unique case (state_reg)
            pli_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    pend_eval_next   = 1'b0;
                    pend_status_next = pli_pkg::ST_OK;
                    state_next       = pli_pkg::S_RESULT;
                    unique case (op)
                        pli_pkg::CMD_LOAD:
                        begin
                            if (stat.count_full)
                                pend_status_next = pli_pkg::ST_FULL;
                            else if (stat.count_zero)
                                state_next = pli_pkg::S_LD_WRITE;
                            else
                                state_next = pli_pkg::S_LD_READ;
                        end
                        pli_pkg::CMD_EVAL:
                        begin
                            if (stat.count_few)
                                pend_status_next = pli_pkg::ST_FEW;
                            else
                            begin
                                pend_eval_next = 1'b1;
                                state_next     = pli_pkg::S_SRCH_START;
                            end
                        end
                        default: state_next = pli_pkg::S_RESULT;
                    endcase
                end
            end
            pli_pkg::S_LD_READ:    state_next = pli_pkg::S_LD_CHECK;
            pli_pkg::S_LD_CHECK:
            begin
                if (stat.order_err)
                begin
                    pend_status_next = pli_pkg::ST_ORDER;
                    state_next       = pli_pkg::S_RESULT;
                end
                else
                    state_next = pli_pkg::S_DIV;
            end
            pli_pkg::S_DIV:
            begin
                if (stat.div_done)
                    state_next = pli_pkg::S_LD_WRITE;
            end
            pli_pkg::S_LD_WRITE:
            begin
                pend_status_next = (!stat.count_zero && stat.slope_sat) ?
                                   pli_pkg::ST_SAT : pli_pkg::ST_OK;
                state_next       = pli_pkg::S_RESULT;
            end
            pli_pkg::S_SRCH_START: state_next = pli_pkg::S_SRCH;
            pli_pkg::S_SRCH:
            begin
                if (stat.search_done)
                    state_next = pli_pkg::S_EV_DIFF;
            end
            pli_pkg::S_EV_DIFF:    state_next = pli_pkg::S_EV_MUL_LO;
            pli_pkg::S_EV_MUL_LO:  state_next = pli_pkg::S_EV_MUL_HI;
            pli_pkg::S_EV_MUL_HI:  state_next = pli_pkg::S_EV_ACC;
            pli_pkg::S_EV_ACC:     state_next = pli_pkg::S_EV_FIN;
            pli_pkg::S_EV_FIN:     state_next = pli_pkg::S_RESULT;
            pli_pkg::S_RESULT:
            begin
                if (out_free)
                    state_next = pli_pkg::S_IDLE;
            end
            default:               state_next = pli_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.addr_sel = pli_pkg::ADDR_MID;
        cmd.res_status = pli_pkg::ST_OK;
        in_ready     = 1'b0;
        unique case (state_reg)
            pli_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                cmd.cnt_clear   = in_valid && (op == pli_pkg::CMD_CLEAR);
                cmd.search_init = in_valid && (op == pli_pkg::CMD_EVAL);
            end
            pli_pkg::S_LD_READ:    cmd.addr_sel = pli_pkg::ADDR_LAST;
            pli_pkg::S_LD_CHECK:   cmd.div_init = 1'b1;
            pli_pkg::S_DIV:        cmd.div_step = 1'b1;
            pli_pkg::S_LD_WRITE:   cmd.knot_wr  = 1'b1;
            pli_pkg::S_SRCH_START: cmd.addr_sel = pli_pkg::ADDR_MID;
            pli_pkg::S_SRCH:
            begin
                cmd.addr_sel    = pli_pkg::ADDR_SRCH;
                cmd.search_step = 1'b1;
            end
            pli_pkg::S_EV_DIFF:    cmd.ev_diff   = 1'b1;
            pli_pkg::S_EV_MUL_LO:  cmd.ev_mul_lo = 1'b1;
            pli_pkg::S_EV_MUL_HI:  cmd.ev_mul_hi = 1'b1;
            pli_pkg::S_EV_ACC:     cmd.ev_acc    = 1'b1;
            pli_pkg::S_EV_FIN:     cmd.ev_fin    = 1'b1;
            pli_pkg::S_RESULT:
            begin
                cmd.res_load = out_free;
                cmd.res_eval = pend_eval_reg;
                if (pend_eval_reg)
                    cmd.res_status = stat.ev_sat ? pli_pkg::ST_SAT : pli_pkg::ST_OK;
                else
                    cmd.res_status = pend_status_reg;
            end
            default:               cmd.addr_sel = pli_pkg::ADDR_MID;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pli_pkg::S_IDLE;
            pend_status_reg <= pli_pkg::ST_OK;
            pend_eval_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pend_status_reg <= pend_status_next;
            pend_eval_reg   <= pend_eval_next;
            if (cmd.res_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> design/piecewise_linear_interpolator.sv
// Top level of the piecewise linear interpolator: controller, datapath, checks.
//
// Usage: the slave stream carries one command per transfer in s_axis_tuser
// (clear table, load knot, evaluate) with the knot or query coordinates in
// s_axis_tdata as signed Q16.16. Every command yields exactly one transfer on
// the master stream: m_axis_tdata holds the interpolated value (zero except
// for a successful or saturated evaluate), m_axis_tuser the status code.
// Knots must be loaded in strictly increasing x; up to 64 are held.
// Timing: one command is worked on at a time. Clear, the unused command and an
// evaluate on fewer than two knots go straight to the result. Evaluate runs a
// binary search (at most ceil(log2(count)) steps, 6 for a full table), paced by
// the one registered read per step of the knot memory, then the two-pass 18x32
// multiplier. A load runs the one bit per cycle restoring divider that forms
// the segment slope; a first knot or a rejected load skips the divider.
// Reset empties the table; knot memories are not cleared, only entries below
// the fill count are ever read. A finished result waits in the output
// register while the receiver stalls; the next command is already taken then,
// but its own result is held back until that register is free.
module piecewise_linear_interpolator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] sample_x, [63:32] sample_y
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic [2:0]  m_axis_tuser    // [2:0] status
);

    pli_pkg::dp_cmd_t  dp_cmd;
    pli_pkg::dp_stat_t dp_stat;

    // Sequencing: accept, walk the load or evaluate steps, hand off the result.
    pli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_cmd    (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

    // Storage and arithmetic; also holds the result payload register.
    pli_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_x   (s_axis_tdata[31:0]),
        .in_y   (s_axis_tdata[63:32]),
        .cmd    (dp_cmd),
        .stat   (dp_stat),
        .value  (m_axis_tdata),
        .status (m_axis_tuser)
    );

    // A command is worked on alone: no transfer right after an accepted one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a command is in progress");

    // A nonzero value only comes with an ok or saturated status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata != 32'd0)) |->
        ((m_axis_tuser == pli_pkg::ST_OK) || (m_axis_tuser == pli_pkg::ST_SAT)))
        else $error("nonzero value with an error status");

    // With the output empty, an accepted command's result does not appear in the cycle after acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result appeared in the cycle after acceptance");

endmodule

>>> bench/pli_checker.sv
// Result checker for the piecewise linear interpolator: predicts and compares every result.
module pli_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0]      value;
        pli_pkg::status_t status;
    } outcome_t;

    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;

    int unsigned        knot_count;
    logic signed [31:0] knot_x [pli_pkg::MAX_POINTS];
    logic signed [31:0] knot_y [pli_pkg::MAX_POINTS];
    logic signed [31:0] slope  [pli_pkg::MAX_POINTS];
    outcome_t           awaited [$];

    // Upper bit flags a clipped value.
    function automatic logic [32:0] saturate_q16(longint v);
        if (v > Q_HI)
            return {1'b1, pli_pkg::Q_MAX};
        if (v < Q_LO)
            return {1'b1, pli_pkg::Q_MIN};
        return {1'b0, v[31:0]};
    endfunction

    function automatic outcome_t apply_command(logic [1:0] op, logic signed [31:0] x,
                                               logic signed [31:0] y);
        outcome_t    res;
        logic [32:0] clipped;
        longint      rise;
        longint      run;
        longint      acc;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned seg;
        res.value  = '0;
        res.status = pli_pkg::ST_OK;
        case (op)
            pli_pkg::CMD_CLEAR:
                knot_count = 0;
            pli_pkg::CMD_LOAD:
                if (knot_count >= pli_pkg::MAX_POINTS)
                    res.status = pli_pkg::ST_FULL;
                else if (knot_count > 0 && x <= knot_x[knot_count - 1])
                    res.status = pli_pkg::ST_ORDER;
                else
                begin
                    if (knot_count > 0)
                    begin
                        // slope of the new segment, truncated toward zero
                        run  = longint'(x) - longint'(knot_x[knot_count - 1]);
                        rise = (longint'(y) - longint'(knot_y[knot_count - 1])) * 65536;
                        clipped = saturate_q16(rise / run);
                        slope[knot_count - 1] = clipped[31:0];
                        if (clipped[32])
                            res.status = pli_pkg::ST_SAT;
                    end
                    knot_x[knot_count] = x;
                    knot_y[knot_count] = y;
                    knot_count++;
                end
            pli_pkg::CMD_EVAL:
                if (knot_count < 2)
                    res.status = pli_pkg::ST_FEW;
                else
                begin
                    // last left x strictly below the query, or the first segment if there is none
                    lo = 0;
                    hi = knot_count - 1;
                    while (lo < hi)
                    begin
                        mid = lo + (hi - lo) / 2;
                        if (knot_x[mid] < x)
                            lo = mid + 1;
                        else
                            hi = mid;
                    end
                    seg = (lo == 0) ? 0 : lo - 1;
                    acc = (longint'(x) - longint'(knot_x[seg])) * longint'(slope[seg]);
                    clipped = saturate_q16((acc >>> 16) + longint'(knot_y[seg]));
                    res.value = clipped[31:0];
                    if (clipped[32])
                        res.status = pli_pkg::ST_SAT;
                end
            default:
                ;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t want;
        int       errs;
        if (!rst_n)
        begin
            knot_count = 0;
            awaited.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = mismatches;
            // a result never leaves in the cycle of its own command, so pop first
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited.size() == 0)
                begin
                    $display("%0t unexpected result: value %h status %0d", $time,
                             m_axis_tdata, m_axis_tuser);
                    errs++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (m_axis_tdata !== want.value)
                    begin
                        $display("%0t value mismatch: expected %h actual %h", $time,
                                 want.value, m_axis_tdata);
                        errs++;
                    end
                    if (m_axis_tuser !== want.status)
                    begin
                        $display("%0t status mismatch: expected %0d actual %0d", $time,
                                 want.status, m_axis_tuser);
                        errs++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited.insert(awaited.size(), apply_command(s_axis_tuser,
                                                             s_axis_tdata[31:0],
                                                             s_axis_tdata[63:32]));
            mismatches  <= errs;
            outstanding <= awaited.size();
        end
    end

endmodule

>>> bench/tb.sv
// Testbench top for the piecewise linear interpolator: stimulus, output stalls and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]         CMD_SPARE   = 2'd3;  // unused command code
    localparam logic signed [31:0] X_MIN       = 32'sh8000_0000;
    localparam logic signed [31:0] X_MAX       = 32'sh7fff_ffff;
    localparam int                 ITEM_TARGET = 1500;
    localparam int                 CALM_TAIL   = 150;   // final commands with no idling
    localparam int                 LONG_HOLD   = 300;   // receiver hold-off, in cycles
    localparam int                 STALL_LIMIT = 2000;  // cycles without any transfer
    localparam int                 DRAIN_WAIT  = 64;    // longer than the slowest load

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [63:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    int     mismatches;
    int     outstanding;
    int     commands_sent = 0;
    int     quiet_cycles;
    bit     calm          = 1'b0;  // no idling on either side
    bit     no_gaps       = 1'b0;  // sender offers back to back
    bit     hold_results  = 1'b0;  // ask the receiver for a long hold-off
    longint knot_xs [$];           // x of the knots the table should hold

    piecewise_linear_interpolator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    pli_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Watchdog: end the run once no transfer has happened on either side for too long.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver: random ready bursts, one long hold-off on request, always ready when calm.
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_results = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // Drop valid and scramble the bus for a number of cycles.
    task automatic stream_idle(input int cycles);
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= 2'($urandom());
        s_axis_tdata  <= {$urandom(), $urandom()};
        repeat (cycles) @(posedge clk);
    endtask

    // Offer one command, hold it until the transfer; valid stays up unless idling follows.
    task automatic send_command(input logic [1:0] op, input longint x, input longint y);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {y[31:0], x[31:0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        commands_sent++;
        calm = (commands_sent >= ITEM_TARGET - CALM_TAIL);
        if (!calm && !no_gaps && $urandom_range(0, 3) == 0)
            stream_idle($urandom_range(1, 16));
    endtask

    // Pick a query: at a knot, inside a segment, beyond either end, anywhere, or an extreme.
    function automatic longint pick_query();
        int     n;
        int     mode;
        int     seg;
        longint reach;
        longint q;
        n    = knot_xs.size();
        mode = (n < 2) ? 3 : $urandom_range(0, 5);
        case (mode)
            0:
                q = knot_xs[$urandom_range(0, n - 1)];
            1:
            begin
                seg = $urandom_range(0, n - 2);
                q   = knot_xs[seg] + $urandom_range(0, 32'(knot_xs[seg + 1] - knot_xs[seg]));
            end
            2:
            begin
                reach = longint'(1) << $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1)
                    q = knot_xs[0] - $urandom_range(1, 32'(reach));
                else
                    q = knot_xs[n - 1] + $urandom_range(1, 32'(reach));
            end
            3:
                q = longint'($signed($urandom()));
            default:
                q = ($urandom_range(0, 1) == 1) ? X_MAX : X_MIN;
        endcase
        if (q < X_MIN)
            q = X_MIN;
        if (q > X_MAX)
            q = X_MAX;
        return q;
    endfunction

    // Noise between loads: a load out of order, the unused command, or a stray query.
    task automatic inject_noise();
        longint x;
        case ($urandom_range(0, 2))
            0:
                if (knot_xs.size() > 0)
                begin
                    x = knot_xs[$] - $urandom_range(0, 4096);
                    if (x < X_MIN)
                        x = X_MIN;
                    send_command(pli_pkg::CMD_LOAD, x, $urandom());
                end
                else
                    send_command(CMD_SPARE, $urandom(), $urandom());
            1:
                send_command(CMD_SPARE, $urandom(), $urandom());
            default:
                send_command(pli_pkg::CMD_EVAL, pick_query(), $urandom());
        endcase
    endtask

    // Build a table of knots with increasing x; mostly from a clear, sometimes appended.
    task automatic load_sequence(input int forced_knots);
        int          knots;
        int          y_style;
        int          k;
        longint      x_pos;
        longint      room;
        longint      cap;
        longint      ceiling;
        logic [31:0] y_val;
        if (forced_knots > 0 || $urandom_range(0, 19) != 0)
        begin
            send_command(pli_pkg::CMD_CLEAR, $urandom(), $urandom());
            knot_xs.delete();
        end
        if (forced_knots > 0)
            knots = forced_knots;
        else if ($urandom_range(0, 7) == 0)
            knots = $urandom_range(62, 66);
        else
            knots = $urandom_range(0, 10);
        if (knot_xs.size() > 0)
            x_pos = knot_xs[$];
        else if ($urandom_range(0, 5) == 0)
            x_pos = X_MIN;
        else
            x_pos = longint'($signed($urandom()));
        room = X_MAX - x_pos;
        if (knot_xs.size() == 0 && room <= knots)
        begin
            x_pos = X_MIN;
            room  = X_MAX - x_pos;
        end
        // spread the knots over the room left, often in much tighter steps
        cap = room / (knots + 1);
        if (cap < 1)
            cap = 1;
        if ($urandom_range(0, 2) != 0)
        begin
            ceiling = longint'(1) << $urandom_range(0, 24);
            if (cap > ceiling)
                cap = ceiling;
        end
        y_style = $urandom_range(0, 2);
        for (k = 0; k < knots; k++)
        begin
            if (k > 0 || knot_xs.size() > 0)
                x_pos += $urandom_range(1, 32'(cap));
            case (y_style)
                0:
                    y_val = $urandom();
                1:
                    y_val = $urandom_range(0, 1 << 21) - (1 << 20);
                default:
                    case ($urandom_range(0, 2))
                        0:       y_val = X_MAX;
                        1:       y_val = X_MIN;
                        default: y_val = '0;
                    endcase
            endcase
            if ($urandom_range(0, 11) == 0)
                inject_noise();
            send_command(pli_pkg::CMD_LOAD, x_pos, y_val);
            if (x_pos <= X_MAX && knot_xs.size() < pli_pkg::MAX_POINTS &&
                (knot_xs.size() == 0 || x_pos > knot_xs[$]))
                knot_xs.insert(knot_xs.size(), x_pos);
        end
    endtask

    task automatic query_sequence();
        repeat ($urandom_range(2, 12))
            send_command(pli_pkg::CMD_EVAL, pick_query(), $urandom());
    endtask

    // Hold the receiver off while queries keep coming, then wait for every result.
    task automatic squeeze_output();
        hold_results = 1'b1;
        no_gaps      = 1'b1;
        repeat (16)
            send_command(pli_pkg::CMD_EVAL, pick_query(), $urandom());
        no_gaps = 1'b0;
        stream_idle(1);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int seq_no;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty and one-knot tables, order errors, extreme coordinates,
        // clipped slopes and results, queries on knots and beyond both ends.
        send_command(pli_pkg::CMD_CLEAR, 0, 0);
        send_command(pli_pkg::CMD_EVAL, 0, 0);
        send_command(CMD_SPARE, X_MAX, X_MIN);
        send_command(pli_pkg::CMD_LOAD, X_MIN, 0);
        send_command(pli_pkg::CMD_EVAL, X_MAX, 0);
        send_command(pli_pkg::CMD_LOAD, X_MIN, 5);
        send_command(pli_pkg::CMD_LOAD, X_MAX, X_MIN);
        send_command(pli_pkg::CMD_EVAL, X_MIN, 0);
        send_command(pli_pkg::CMD_EVAL, X_MAX, X_MAX);
        send_command(pli_pkg::CMD_EVAL, 0, 0);
        send_command(pli_pkg::CMD_LOAD, X_MAX, 0);
        send_command(pli_pkg::CMD_CLEAR, X_MAX, X_MAX);
        send_command(pli_pkg::CMD_LOAD, 0, 0);
        send_command(pli_pkg::CMD_LOAD, 1, X_MAX);
        send_command(pli_pkg::CMD_EVAL, 2, 0);
        send_command(pli_pkg::CMD_EVAL, X_MIN, 0);
        send_command(pli_pkg::CMD_LOAD, 2, X_MIN);
        send_command(pli_pkg::CMD_EVAL, 1, 0);
        send_command(pli_pkg::CMD_EVAL, 3, 0);
        send_command(pli_pkg::CMD_EVAL, X_MAX, 0);
        send_command(pli_pkg::CMD_EVAL, -1, 0);
        send_command(pli_pkg::CMD_EVAL, 32'h0000_ffff, 0);
        send_command(CMD_SPARE, 0, 0);

        // Random: the first table overfills, later ones mostly stay small.
        knot_xs.delete();
        load_sequence(66);
        query_sequence();
        seq_no = 1;
        while (commands_sent < ITEM_TARGET)
        begin
            if (seq_no == 12)
                squeeze_output();
            load_sequence(0);
            query_sequence();
            seq_no++;
        end

        stream_idle(1);
        wait (outstanding == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
design/pli_pkg.sv
design/pli_dp.sv
design/pli_ctrl.sv
design/piecewise_linear_interpolator.sv
bench/pli_checker.sv
bench/tb.sv
